### rtl/core/ihwl_pkg.sv
`timescale 1ns / 1ps

package ihwl_pkg;

  // sticky error codes reported on error_code
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_COLON  = 3'd1,
    ERR_BAD_HEX   = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_RANGE     = 3'd4
  } err_t;

  localparam int unsigned MemWordsDefault = 32 * 1024;

  localparam logic [7:0] CharColon   = 8'h3a;
  localparam logic [7:0] CharNewline = 8'h0a;

  // fixed line positions of the record layout
  localparam logic [9:0] PosCountLow = 10'd2;
  localparam logic [9:0] PosAddrLow  = 10'd6;
  localparam logic [9:0] PosTypeEnd  = 10'd7;
  localparam logic [9:0] PosDataBase = 10'd9;
  localparam logic [9:0] PosEndMatch = 10'd11;
  localparam logic [9:0] PosMax      = 10'd1023;

  // one decoded character handed from the input stage to the parser
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_newline;
    logic       is_colon;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_info_t;

  // ascii hex digit decode, upper and lower case
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // characters of the end-of-file line ":00000001FF"
  function automatic logic [7:0] end_pattern(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h3a;
      4'd8:    r = 8'h31;
      4'd9:    r = 8'h46;
      4'd10:   r = 8'h46;
      default: r = 8'h30;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/ihwl_char_stage.sv
`timescale 1ns / 1ps

module ihwl_char_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_in,
  output logic                s1_valid,
  input  logic                s1_ready,
  output ihwl_pkg::char_info_t s1_info
);
  import ihwl_pkg::*;

  logic [4:0] hex_dec;
  logic       accept;

  // take a new request whenever the register is empty or drains this cycle
  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;
  assign hex_dec  = hex_decode(char_in);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // decoded character register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info.char_code  <= char_in;
      s1_info.is_newline <= (char_in == CharNewline);
      s1_info.is_colon   <= (char_in == CharColon);
      s1_info.hex_ok     <= hex_dec[4];
      s1_info.hex_val    <= hex_dec[3:0];
    end
  end

endmodule

### rtl/core/ihwl_parser.sv
`timescale 1ns / 1ps

module ihwl_parser #(
  parameter int unsigned MEM_WORDS = ihwl_pkg::MemWordsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s1_valid,
  output logic                 s1_ready,
  input  ihwl_pkg::char_info_t s1_info,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 write_valid,
  output logic [14:0]          word_address,
  output logic [15:0]          word_data,
  output logic                 finished,
  output logic [2:0]           error_code
);
  import ihwl_pkg::*;

  localparam logic [16:0] MemLimit = 17'(MEM_WORDS);

  // line parse state
  logic [9:0]  line_position, line_position_next;
  logic [7:0]  record_byte_count, record_byte_count_next;
  logic [15:0] record_address, record_address_next;
  logic [15:0] digit_accumulator, digit_accumulator_next;
  logic        end_record_match, end_record_match_next;
  logic        done_flag, done_flag_next;
  err_t        sticky_error, sticky_error_next;

  logic        consume;
  logic        active;
  logic [6:0]  words;
  logic [9:0]  data_end;
  logic [9:0]  need;
  logic        in_data;
  logic        in_header;
  logic [15:0] acc_shift;
  logic [9:0]  data_off;
  logic [6:0]  word_idx;
  logic [16:0] addr_full;
  logic        match_next;
  logic        ok;
  logic        wv_next;
  logic [14:0] waddr_next;
  logic [15:0] wdata_next;

  // the parser advances when the result register is empty or drains this cycle
  assign s1_ready = !out_valid || out_ready;
  assign consume  = s1_valid && s1_ready;

  // record geometry
  assign active    = !done_flag && (sticky_error == ERR_NONE);
  assign words     = record_byte_count[7:1];
  assign data_end  = PosDataBase + {1'b0, words, 2'b00};
  assign need      = (words == 7'd0) ? PosTypeEnd : data_end;
  assign in_header = (line_position != 10'd0) && (line_position <= PosAddrLow);
  assign in_data   = (line_position >= PosDataBase) && (line_position < data_end);
  assign acc_shift = {digit_accumulator[11:0], s1_info.hex_val};
  assign data_off  = line_position - PosDataBase;
  assign word_idx  = data_off[8:2];
  assign addr_full = {2'b00, record_address[15:1]} + {10'd0, word_idx};
  assign match_next = end_record_match &&
                      (s1_info.char_code == end_pattern(line_position[3:0]));

  // next state and write decision
  always_comb begin
    line_position_next     = line_position;
    record_byte_count_next = record_byte_count;
    record_address_next    = record_address;
    digit_accumulator_next = digit_accumulator;
    end_record_match_next  = end_record_match;
    done_flag_next         = done_flag;
    sticky_error_next      = sticky_error;
    ok                     = 1'b1;
    wv_next                = 1'b0;
    waddr_next             = 15'd0;
    wdata_next             = 16'd0;
    if (active) begin
      if (s1_info.is_newline) begin
        if (line_position == 10'd0) begin
          sticky_error_next = ERR_NO_COLON;
        end else if (line_position < PosTypeEnd || line_position < need) begin
          sticky_error_next = ERR_TRUNCATED;
        end else begin
          line_position_next     = 10'd0;
          end_record_match_next  = 1'b1;
          digit_accumulator_next = 16'd0;
        end
      end else begin
        if (line_position == 10'd0) begin
          if (!s1_info.is_colon) begin
            sticky_error_next = ERR_NO_COLON;
            ok = 1'b0;
          end
        end else if (in_header || in_data) begin
          if (!s1_info.hex_ok) begin
            sticky_error_next = ERR_BAD_HEX;
            ok = 1'b0;
          end else begin
            digit_accumulator_next = acc_shift;
            if (line_position == PosCountLow) begin
              record_byte_count_next = acc_shift[7:0];
            end
            if (line_position == PosAddrLow) begin
              record_address_next = acc_shift;
            end
            // last digit of a data word
            if (in_data && data_off[1:0] == 2'b11) begin
              if (addr_full >= MemLimit) begin
                sticky_error_next = ERR_RANGE;
                ok = 1'b0;
              end else begin
                wv_next    = 1'b1;
                waddr_next = addr_full[14:0];
                wdata_next = {acc_shift[7:0], acc_shift[15:8]};
              end
            end
          end
        end
        if (ok) begin
          if (line_position < PosEndMatch) begin
            end_record_match_next = match_next;
            if (line_position == PosEndMatch - 10'd1 && match_next) begin
              done_flag_next = 1'b1;
            end
          end
          if (line_position != PosMax) begin
            line_position_next = line_position + 10'd1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position     <= 10'd0;
      record_byte_count <= 8'd0;
      record_address    <= 16'd0;
      digit_accumulator <= 16'd0;
      end_record_match  <= 1'b1;
      done_flag         <= 1'b0;
      sticky_error      <= ERR_NONE;
    end else if (consume) begin
      line_position     <= line_position_next;
      record_byte_count <= record_byte_count_next;
      record_address    <= record_address_next;
      digit_accumulator <= digit_accumulator_next;
      end_record_match  <= end_record_match_next;
      done_flag         <= done_flag_next;
      sticky_error      <= sticky_error_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (consume) begin
      write_valid  <= wv_next;
      word_address <= waddr_next;
      word_data    <= wdata_next;
      finished     <= done_flag_next;
      error_code   <= sticky_error_next;
    end
  end

endmodule

### rtl/core/intel_hex_word_loader_unit.sv
`timescale 1ns / 1ps
// Intel HEX word loader.
// Input channel: in_valid / in_ready carry one character of the hex file per
// request on char_in; a line feed ends a line.
// Output channel: out_valid / out_ready carry one result per character:
// write_valid with word_address and word_data (a byte-swapped program word),
// plus the running finished flag and the sticky error_code.
// The result of a character is offered once it has passed the decoded
// character register and then gone through the parser into the result
// register.
// Throughput: one character per cycle unless stalled; the parse state
// updates in a single pass between the character and result registers.
// Reset (rst, synchronous) empties both registers and restarts parsing at the
// start of a line with no error and the end-of-file flag clear.
// When the receiver stalls the result register holds its request, the
// character register takes one more character only if it was empty, and
// in_ready then drops until out_ready returns.
// After the end-of-file line or an error, characters are still taken; their
// results repeat finished and error_code with no write.
module intel_hex_word_loader_unit #(
  parameter int unsigned MEM_WORDS = ihwl_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_valid,
  output logic [14:0] word_address,
  output logic [15:0] word_data,
  output logic        finished,
  output logic [2:0]  error_code
);
  import ihwl_pkg::*;

  logic       s1_valid;
  logic       s1_ready;
  char_info_t s1_info;

  // character register and hex decode
  ihwl_char_stage u_char (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_in  (char_in),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_info  (s1_info)
  );

  // line parser and result register
  ihwl_parser #(
    .MEM_WORDS (MEM_WORDS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1_info      (s1_info),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .word_address (word_address),
    .word_data    (word_data),
    .finished     (finished),
    .error_code   (error_code)
  );

endmodule

### rtl/core/ihwl_checker.sv
`timescale 1ns / 1ps

module ihwl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_valid,
  input logic [14:0] word_address,
  input logic [15:0] word_data,
  input logic        finished,
  input logic [2:0]  error_code
);
  import ihwl_pkg::*;

  logic [2:0] last_err;
  logic       last_fin;

  // remember status of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= ERR_NONE;
      last_fin <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        last_err <= error_code;
        last_fin <= finished;
      end
    end
  end

  // an error once reported never changes
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_err != ERR_NONE |-> error_code == last_err)
    else $error("error_code changed after an error was reported");

  // end of file once reported stays
  a_fin_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_fin |-> finished)
    else $error("finished dropped after end of file");

  // writes only while parsing is live, and idle results carry zero payload
  a_write_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> error_code == ERR_NONE && !finished)
    else $error("write emitted after finish or error");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> word_address == 15'd0 && word_data == 16'd0)
    else $error("nonzero payload without a write");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_data) &&
      $stable(word_address) && $stable(error_code) && $stable(write_valid) &&
      $stable(finished))
    else $error("result changed while stalled");

endmodule

bind intel_hex_word_loader_unit ihwl_checker u_ihwl_checker (.*);
